/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion shorthands, clocked on i_clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define IPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression must never be true at an edge out of reset
`define IPC_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

/* src/ipc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg
// shared types, codes and helpers of the ipv4 checksum core
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] POS_LIMIT  = 16'hFFFF;
    localparam logic [3:0]  IHL_MIN    = 4'd5;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    // register index of checksum_select
    localparam logic REG_SELECT = 1'b0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_BAD_HDR = 2'd2
    } t_status;

    // one classified beat handed from front to back
    typedef struct packed {
        logic [15:0] word;
        logic        add_h;
        logic        add_p;
        logic        last;
        logic [7:0]  proto;
        logic [15:0] pseudo;
        t_status     status;
    } t_op;

    // ones-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

/* src/ipc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_front
// parses the header fields, zeroes check fields and routes each 16-bit word
// ----------------------------------------------------------------------------
module ipc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    input  logic           i_full,
    output logic           o_ready,
    output logic           o_push,
    output ipc_pkg::t_op   o_op
);
    import ipc_pkg::*;

    logic [15:0] r_pos, n_pos;
    logic [3:0]  r_ihl, n_ihl;
    logic [15:0] r_tlen, n_tlen;
    logic [7:0]  r_proto, n_proto;
    logic [7:0]  r_pend, n_pend;

    logic        accept;
    logic        taken;
    logic [15:0] hl;
    logic [15:0] q;
    logic [15:0] e;
    logic        counts;
    logic [7:0]  c;
    logic        tcp_udp;
    logic        emit;
    logic [15:0] pay_len;
    t_status     status;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign taken   = (r_pos != POS_LIMIT);

    always_comb begin
        n_ihl   = r_ihl;
        n_tlen  = r_tlen;
        n_proto = r_proto;
        if (taken && r_pos == 16'd0) begin
            n_ihl = i_byte[3:0];
        end
        if (taken && r_pos == 16'd2) begin
            n_tlen = {i_byte, r_tlen[7:0]};
        end
        if (taken && r_pos == 16'd3) begin
            n_tlen = {r_tlen[15:8], i_byte};
        end
        if (taken && r_pos == 16'd9) begin
            n_proto = i_byte;
        end
    end

    assign hl      = {10'd0, n_ihl, 2'b00};
    assign q       = r_pos - hl;
    assign tcp_udp = (n_proto == PROTO_TCP) || (n_proto == PROTO_UDP);

    // decide whether this byte takes part in the sum
    always_comb begin
        if (r_pos < hl) begin
            counts = !(r_pos == 16'd10 || r_pos == 16'd11);
        end else if (r_pos >= n_tlen) begin
            counts = 1'b0;
        end else begin
            case (n_proto)
                PROTO_TCP:  counts = !(q == 16'd16 || q == 16'd17);
                PROTO_UDP:  counts = !(q == 16'd6 || q == 16'd7);
                PROTO_ICMP: counts = !(q == 16'd2 || q == 16'd3);
                default:    counts = 1'b1;
            endcase
        end
    end

    assign c = counts ? i_byte : 8'd0;

    // a word closes on an odd byte, or a padded one closes on the last beat
    assign emit = (taken && r_pos[0]) || i_last;
    assign e    = {r_pos[15:1], 1'b0};

    assign n_pos  = taken ? (r_pos + 16'd1) : r_pos;
    assign n_pend = (taken && !r_pos[0]) ? c : r_pend;

    assign pay_len = (n_tlen >= hl) ? (n_tlen - hl) : 16'd0;

    always_comb begin
        if (n_ihl < IHL_MIN || n_tlen < hl) begin
            status = ST_BAD_HDR;
        end else if (n_pos < n_tlen) begin
            status = ST_SHORT;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_op.word   = {n_pend, (taken && r_pos[0]) ? c : 8'd0};
        o_op.add_h  = 1'b0;
        o_op.add_p  = 1'b0;
        if (e < hl) begin
            o_op.add_h = 1'b1;
            o_op.add_p = (e >= 16'd12) && (e <= 16'd18) && tcp_udp;
        end else if (e < n_tlen) begin
            o_op.add_p = 1'b1;
        end
        o_op.last   = i_last;
        o_op.proto  = n_proto;
        o_op.pseudo = tcp_udp ? oc_add({8'd0, n_proto}, pay_len) : 16'd0;
        o_op.status = status;
    end

    assign o_push = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ihl   <= '0;
            r_tlen  <= '0;
            r_proto <= '0;
            r_pend  <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_pos   <= '0;
                r_ihl   <= '0;
                r_tlen  <= '0;
                r_proto <= '0;
                r_pend  <= '0;
            end else begin
                r_pos   <= n_pos;
                r_ihl   <= n_ihl;
                r_tlen  <= n_tlen;
                r_proto <= n_proto;
                r_pend  <= n_pend;
            end
        end
    end

`include "assert_macros.svh"

    `IPC_ASSERT(a_front_clear, (accept && i_last) |=> (r_pos == 16'd0 && r_ihl == 4'd0), "packet state not cleared after last beat")
    `IPC_ASSERT(a_front_sat, (accept && !i_last && !taken) |=> (r_pos == POS_LIMIT), "byte position left saturation")

endmodule

/* src/ipc_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_fifo
// short queue of classified beats between front and back
// ----------------------------------------------------------------------------
module ipc_fifo #(
    parameter int DEPTH = ipc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ipc_pkg::t_op   i_entry,
    input  logic           i_pop,
    output ipc_pkg::t_op   o_head,
    output logic           o_full,
    output logic           o_empty
);
    import ipc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`include "assert_macros.svh"

    `IPC_NEVER(a_fifo_overrun, i_push && o_full, "beat pushed into full queue")
    `IPC_NEVER(a_fifo_underrun, i_pop && o_empty, "beat popped from empty queue")

endmodule

/* src/ipc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_back
// accumulates header and payload sums and registers the finished result
// ----------------------------------------------------------------------------
module ipc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_sel,
    input  logic               i_empty,
    input  ipc_pkg::t_op       i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_checksum,
    output logic [7:0]         o_proto,
    output ipc_pkg::t_status   o_status
);
    import ipc_pkg::*;

    logic [15:0] r_hsum;
    logic [15:0] r_psum;
    logic        r_valid;
    logic [15:0] r_checksum;
    logic [7:0]  r_proto;
    t_status     r_status;

    logic [15:0] n_hsum;
    logic [15:0] n_psum;
    logic [15:0] n_final;

    assign n_hsum  = oc_add(r_hsum, i_head.add_h ? i_head.word : 16'd0);
    assign n_psum  = oc_add(r_psum, i_head.add_p ? i_head.word : 16'd0);
    assign n_final = i_sel ? oc_add(n_psum, i_head.pseudo) : n_hsum;

    // a closing beat waits until the output register is free
    assign o_pop = !i_empty && (!i_head.last || !r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hsum  <= '0;
            r_psum  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop && i_head.last) begin
                r_hsum  <= '0;
                r_psum  <= '0;
                r_valid <= 1'b1;
            end else begin
                if (o_pop) begin
                    r_hsum <= n_hsum;
                    r_psum <= n_psum;
                end
                if (i_ready) begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_checksum <= ~n_final;
            r_proto    <= i_head.proto;
            r_status   <= i_head.status;
        end
    end

    assign o_valid    = r_valid;
    assign o_checksum = r_checksum;
    assign o_proto    = r_proto;
    assign o_status   = r_status;

`include "assert_macros.svh"

    `IPC_ASSERT(a_back_close, (o_pop && i_head.last) |=> (r_valid && r_hsum == 16'd0 && r_psum == 16'd0), "result not loaded or sums not cleared")

endmodule

/* src/ipv4_packet_checksum_core.sv */
`timescale 1ns / 1ps
// result: the last beat is queued in the fifo, and its pop loads the output register
//   and sets m_axis_tvalid while that register is free; a held result keeps the closing beat queued
// throughput: one packet byte per cycle while the queue has room; a full queue
//   holds s_axis_tready low
// reset: i_rst_n is synchronous, active low; it clears packet state, the queue,
//   the output valid and checksum_select, no clearing pass is needed
// ----------------------------------------------------------------------------
// ipv4_packet_checksum_core
// streaming ipv4 header or transport checksum with an apb select register
// ----------------------------------------------------------------------------
module ipv4_packet_checksum_core #(
    parameter int QDEPTH = ipc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] checksum, [23:16] protocol_seen,
                                        // [25:24] status, [31:26] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ipc_pkg::*;

    logic        r_sel;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_op         op_in;
    t_op         op_head;
    logic [15:0] checksum;
    logic [7:0]  proto;
    t_status     status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SELECT) begin
            r_sel <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_SELECT) ? {31'd0, r_sel} : 32'd0;

    ipc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (full),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_op    (op_in)
    );

    ipc_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (op_in),
        .i_pop   (pop),
        .o_head  (op_head),
        .o_full  (full),
        .o_empty (empty)
    );

    ipc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sel      (r_sel),
        .i_empty    (empty),
        .i_head     (op_head),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_checksum (checksum),
        .o_proto    (proto),
        .o_status   (status)
    );

    assign m_axis_tdata = {6'd0, status, proto, checksum};

endmodule
